FILE: hw/rtl/rtpfu_pkg.sv
// shared types and constants of the h.264 rtp fu-a packetizer
package rtpfu_pkg;

   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1400;
   localparam logic [16:0] TS_STEP_RESET     = 17'd3000;

   localparam logic [7:0] NRI_MASK      = 8'h60;
   localparam logic [7:0] FU_A_TYPE     = 8'd28;
   localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
   localparam logic [4:0] NAL_TYPE_PPS  = 5'd8;
   localparam logic [7:0] FU_START_FLAG = 8'h80;
   localparam logic [7:0] FU_END_FLAG   = 8'h40;

   // register word index (paddr[2])
   localparam logic REG_MAX_PAYLOAD = 1'b0;
   localparam logic REG_TS_STEP     = 1'b1;

   typedef struct packed {
      logic [7:0]  nal_byte;
      logic [15:0] nal_length;
      logic        nal_last;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        packet_last;
      logic [15:0] seq_number;
      logic [31:0] rtp_timestamp;
      logic        run_last;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] max_payload;
      logic [16:0] ts_step;
   } cfg_type;

   // everything one accepted byte produces
   typedef struct packed {
      logic        emit;
      logic        fu;
      logic [7:0]  indicator;
      logic [7:0]  fu_header;
      logic [7:0]  data;
      logic        pkt_end;
      logic [15:0] seq;
      logic [31:0] stamp;
   } plan_type;

   typedef enum logic [1:0] {
      PHASE_INDICATOR = 2'd0,
      PHASE_HEADER    = 2'd1,
      PHASE_DATA      = 2'd2
   } phase_type;

endpackage

FILE: hw/rtl/rtpfu_planner.sv
// per-byte packetizing decision and unit/packet state
module rtpfu_planner import rtpfu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_item_type item,
   input  cfg_type      cfg,
   output plan_type     plan
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] fill_ff, fill_in;
   logic        frag_ff, frag_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] seq_ff, seq_in;
   logic [31:0] time_ff, time_in;

   logic [15:0] len_eff;
   logic [15:0] mp;
   logic [16:0] pos_inc;
   logic [16:0] fill_inc;
   logic        first;
   logic        unit_end;
   logic        frag_now;
   logic [7:0]  header;
   logic [15:0] rem;
   logic        pkt_end;
   logic [4:0]  nal_type;
   logic        ts_skip;

   always_comb begin
      len_eff  = (item.nal_length == 16'd0) ? 16'd1 : item.nal_length;
      mp       = (cfg.max_payload == 16'd0) ? 16'd1 : cfg.max_payload;
      pos_inc  = {1'b0, pos_ff} + 17'd1;
      fill_inc = {1'b0, fill_ff} + 17'd1;
      first    = (pos_ff == 16'd0);
      unit_end = item.nal_last || (pos_inc >= {1'b0, len_eff});
      frag_now = first ? (len_eff > mp) : frag_ff;
      header   = first ? item.nal_byte : held_ff;
      rem      = (len_eff > pos_ff) ? (len_eff - pos_ff) : 16'd0;
      nal_type = header[4:0];

      plan.emit      = !(first && frag_now);
      plan.fu        = frag_now && !first && (fill_ff == 16'd0);
      plan.indicator = (header & NRI_MASK) | FU_A_TYPE;
      plan.fu_header = {3'b000, nal_type}
                     | ((pos_ff == 16'd1) ? FU_START_FLAG : 8'h00)
                     | ((rem <= mp) ? FU_END_FLAG : 8'h00);
      plan.data      = item.nal_byte;
      plan.seq       = seq_ff;
      plan.stamp     = time_ff;

      if (frag_now && !first) begin
         pkt_end = unit_end || (fill_inc >= {1'b0, mp});
      end else if (frag_now) begin
         pkt_end = 1'b0;
      end else begin
         pkt_end = unit_end;
      end
      plan.pkt_end = pkt_end;

      // unfragmented sps and pps share the next unit's timestamp
      ts_skip = !frag_now && ((nal_type == NAL_TYPE_SPS) || (nal_type == NAL_TYPE_PPS));
   end

   always_comb begin
      pos_in  = pos_ff;
      fill_in = fill_ff;
      frag_in = frag_ff;
      held_in = held_ff;
      seq_in  = seq_ff;
      time_in = time_ff;
      if (accept) begin
         held_in = header;
         if (pkt_end) begin
            seq_in = seq_ff + 16'd1;
         end
         if (unit_end) begin
            pos_in  = 16'd0;
            fill_in = 16'd0;
            frag_in = 1'b0;
            if (!ts_skip) begin
               time_in = time_ff + {15'd0, cfg.ts_step};
            end
         end else begin
            pos_in  = pos_inc[15:0];
            frag_in = frag_now;
            if (frag_now && !first) begin
               fill_in = pkt_end ? 16'd0 : fill_inc[15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         fill_ff <= '0;
         frag_ff <= 1'b0;
         held_ff <= '0;
         seq_ff  <= '0;
         time_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         fill_ff <= fill_in;
         frag_ff <= frag_in;
         held_ff <= held_in;
         seq_ff  <= seq_in;
         time_ff <= time_in;
      end
   end

endmodule

FILE: hw/rtl/h264_rtp_fu_a_packetizer.sv
// H.264 RTP FU-A packetizer: takes one NAL unit byte per transaction and
// produces the RTP payload bytes. An accepted byte yields no result (header
// byte of a fragmented unit), one result (a payload byte), or three results
// (FU indicator, FU header and the first data byte of a fragment). Input is
// taken in every cycle while the result port is not stalled; the two extra
// bytes at each fragment start also hold the input off, since the result port
// carries a single byte. A result passes through the decision register, then
// the output register. Registers: max_payload at 0x0, timestamp_step at 0x4.
module h264_rtp_fu_a_packetizer import rtpfu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   cfg_type      cfg_ff, cfg_in;
   plan_type     plan;
   plan_type     plan_ff, plan_in;
   logic         plan_valid_ff, plan_valid_in;
   phase_type    phase_ff, phase_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_ff, out_in;
   rsp_item_type sel;
   logic         accept;
   logic         pop;
   logic         pop_last;

   // configuration registers
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_MAX_PAYLOAD: cfg_in.max_payload = pwdata[15:0];
            REG_TS_STEP:     cfg_in.ts_step     = pwdata[16:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_MAX_PAYLOAD: prdata = {16'd0, cfg_ff.max_payload};
         REG_TS_STEP:     prdata = {15'd0, cfg_ff.ts_step};
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_payload <= MAX_PAYLOAD_RESET;
         cfg_ff.ts_step     <= TS_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rtpfu_planner u_planner (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_data),
      .cfg    (cfg_ff),
      .plan   (plan)
   );

   // decision register drains into the output register one byte per cycle unless the receiver stalls
   assign pop       = plan_valid_ff && (!out_valid_ff || rsp_ready);
   assign pop_last  = pop && (phase_ff == PHASE_DATA);
   assign req_ready = !plan_valid_ff || pop_last;
   assign accept    = req_valid && req_ready;

   // next state
   always_comb begin
      plan_in       = plan_ff;
      plan_valid_in = plan_valid_ff;
      phase_in      = phase_ff;
      if (accept && plan.emit) begin
         plan_in       = plan;
         plan_valid_in = 1'b1;
         phase_in      = plan.fu ? PHASE_INDICATOR : PHASE_DATA;
      end else if (pop) begin
         unique case (phase_ff)
            PHASE_INDICATOR: phase_in = PHASE_HEADER;
            PHASE_HEADER:    phase_in = PHASE_DATA;
            PHASE_DATA:      plan_valid_in = 1'b0;
            default:         phase_in = PHASE_DATA;
         endcase
      end
   end

   // outputs
   always_comb begin
      sel.seq_number    = plan_ff.seq;
      sel.rtp_timestamp = plan_ff.stamp;
      unique case (phase_ff)
         PHASE_INDICATOR: begin
            sel.out_byte    = plan_ff.indicator;
            sel.packet_last = 1'b0;
            sel.run_last    = 1'b0;
         end
         PHASE_HEADER: begin
            sel.out_byte    = plan_ff.fu_header;
            sel.packet_last = 1'b0;
            sel.run_last    = 1'b0;
         end
         default: begin
            sel.out_byte    = plan_ff.data;
            sel.packet_last = plan_ff.pkt_end;
            sel.run_last    = 1'b1;
         end
      endcase
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_in       = sel;
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_valid_ff <= 1'b0;
         phase_ff      <= PHASE_DATA;
         out_valid_ff  <= 1'b0;
      end else begin
         plan_valid_ff <= plan_valid_in;
         phase_ff      <= phase_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // fu bytes still queued block new input
   assert property (@(posedge clock) disable iff (reset)
      plan_valid_ff && (phase_ff != PHASE_DATA) |-> !req_ready)
      else $error("input taken while fu bytes pending");

   assert property (@(posedge clock) disable iff (reset)
      pop && (phase_ff == PHASE_INDICATOR) |=> plan_valid_ff && (phase_ff == PHASE_HEADER))
      else $error("fu header did not follow indicator");

   // a result that is not the last of its run has its followers queued
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.run_last |-> plan_valid_ff)
      else $error("run cut short");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.packet_last |-> rsp_data.run_last)
      else $error("packet end on an fu header byte");

endmodule

FILE: sim/rtp_payload_checker.sv
// checker for the fu-a packetizer: watches request, result and register-write ports, predicts payload bytes, compares
module rtp_payload_checker import rtpfu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_item_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_item_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic         pready,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output int           fail_count,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0] max_pl;
   logic [16:0] ts_step;
   logic [7:0]  held_hdr;
   logic [15:0] unit_pos;
   logic [15:0] frag_fill;
   logic        in_fu;
   logic [15:0] seq;
   logic [31:0] stamp;

   rsp_item_type payload_bytes_due[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic rsp_item_type payload_byte(logic [7:0] b, logic pend);
      rsp_item_type r;
      r.out_byte      = b;
      r.packet_last   = pend;
      r.seq_number    = seq;
      r.rtp_timestamp = stamp;
      r.run_last      = 1'b0;
      return r;
   endfunction

   // one accepted nal byte: 0, 1 or 3 payload bytes
   task automatic packetize_byte(req_item_type it);
      rsp_item_type outs[3];
      int           n;
      logic [15:0]  len;
      logic [15:0]  mp;
      logic [16:0]  rem;
      logic [7:0]   fu_hdr;
      logic [4:0]   nal_type;
      logic         unit_end;
      logic         pkt_end;
      n       = 0;
      pkt_end = 1'b0;
      len      = (it.nal_length == 16'd0) ? 16'd1 : it.nal_length;
      mp       = (max_pl == 16'd0) ? 16'd1 : max_pl;
      unit_end = it.nal_last || ({1'b0, unit_pos} + 17'd1 >= {1'b0, len});
      if (unit_pos == 16'd0) begin
         held_hdr = it.nal_byte;
         in_fu    = len > mp;
         if (!in_fu) begin
            pkt_end = unit_end;
            outs[n] = payload_byte(it.nal_byte, pkt_end);
            n++;
         end
      end else if (!in_fu) begin
         pkt_end = unit_end;
         outs[n] = payload_byte(it.nal_byte, pkt_end);
         n++;
      end else begin
         if (frag_fill == 16'd0) begin
            fu_hdr = {3'b000, held_hdr[4:0]};
            rem    = (len > unit_pos) ? {1'b0, len} - {1'b0, unit_pos} : 17'd0;
            if (unit_pos == 16'd1)
               fu_hdr = fu_hdr | FU_START_FLAG;
            if (rem <= {1'b0, mp})
               fu_hdr = fu_hdr | FU_END_FLAG;
            outs[n] = payload_byte((held_hdr & NRI_MASK) | FU_A_TYPE, 1'b0);
            n++;
            outs[n] = payload_byte(fu_hdr, 1'b0);
            n++;
         end
         pkt_end   = unit_end || ({1'b0, frag_fill} + 17'd1 >= {1'b0, mp});
         outs[n]   = payload_byte(it.nal_byte, pkt_end);
         n++;
         frag_fill = pkt_end ? 16'd0 : frag_fill + 16'd1;
      end
      if (n > 0)
         outs[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++)
         payload_bytes_due.push_back(outs[i]);
      if (pkt_end)
         seq = seq + 16'd1;
      if (unit_end) begin
         nal_type = held_hdr[4:0];
         // unfragmented parameter sets share the timestamp of the next unit
         if (in_fu || (nal_type != NAL_TYPE_SPS && nal_type != NAL_TYPE_PPS))
            stamp = stamp + {15'd0, ts_step};
         unit_pos  = 16'd0;
         frag_fill = 16'd0;
         in_fu     = 1'b0;
      end else begin
         unit_pos = unit_pos + 16'd1;
      end
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         max_pl    = MAX_PAYLOAD_RESET;
         ts_step   = TS_STEP_RESET;
         held_hdr  = 8'd0;
         unit_pos  = 16'd0;
         frag_fill = 16'd0;
         in_fu     = 1'b0;
         seq       = 16'd0;
         stamp     = 32'd0;
         payload_bytes_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (payload_bytes_due.size() == 0) begin
               $error("unexpected payload byte 0x%0h", rsp_data.out_byte);
               fail_count++;
            end else begin
               want = payload_bytes_due.pop_front();
               check_field("out_byte", 32'(want.out_byte), 32'(rsp_data.out_byte));
               check_field("packet_last", 32'(want.packet_last), 32'(rsp_data.packet_last));
               check_field("seq_number", 32'(want.seq_number), 32'(rsp_data.seq_number));
               check_field("rtp_timestamp", want.rtp_timestamp, rsp_data.rtp_timestamp);
               check_field("run_last", 32'(want.run_last), 32'(rsp_data.run_last));
            end
         end
         if (req_valid && req_ready)
            packetize_byte(req_data);
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_MAX_PAYLOAD)
               max_pl = pwdata[15:0];
            else
               ts_step = pwdata[16:0];
         end
      end
      pending = payload_bytes_due.size();
   end

endmodule

FILE: sim/tb.sv
// stimulus and verdict for the fu-a packetizer test
module tb import rtpfu_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_data;
   logic         psel      = 1'b0;
   logic         penable   = 1'b0;
   logic         pwrite    = 1'b0;
   logic [2:0]   paddr     = '0;
   logic [31:0]  pwdata    = '0;
   logic [31:0]  prdata;
   logic         pready;

   int            fail_count;
   int            pending;
   int            items_sent = 0;
   idle_mode_type idle_mode  = IDLE_NONE;
   int            stall_req  = 0;
   int            stall_ack  = 0;
   int            stall_left = 0;

   h264_rtp_fu_a_packetizer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   rtp_payload_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // receiver side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_req != stall_ack) begin
         stall_ack  <= stall_req;
         stall_left <= 300;
         rsp_ready  <= 1'b0;
      end else if (idle_mode == IDLE_RECV) begin
         rsp_ready <= $urandom_range(99) >= 60;
      end else if (idle_mode == IDLE_BOTH) begin
         rsp_ready <= $urandom_range(99) >= 22;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_nal_byte(input logic [7:0] b, input logic [15:0] len, input logic last);
      int gap_pct;
      gap_pct = (idle_mode == IDLE_SEND) ? 60 : (idle_mode == IDLE_BOTH) ? 22 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{nal_byte: b, nal_length: len, nal_last: last};
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_nal_unit(input logic [15:0] len, input int count, input bit mark_last,
                                input logic [7:0] hdr);
      for (int i = 0; i < count; i++)
         send_nal_byte((i == 0) ? hdr : 8'($urandom), len, mark_last && (i == count - 1));
   endtask

   // stop sending and let every outstanding payload byte come out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic logic [7:0] nal_header();
      logic [7:0] h;
      h = 8'($urandom);
      if ($urandom_range(4) == 0)
         h[4:0] = $urandom_range(1) ? NAL_TYPE_SPS : NAL_TYPE_PPS;
      return h;
   endfunction

   task automatic run_phase(input int n_items, input int unsigned mp, input bit mid_pause,
                            input bit mid_stall);
      int          start;
      int unsigned cap;
      int unsigned len;
      int unsigned cnt;
      int unsigned pick;
      bit          halfway;
      start   = items_sent;
      halfway = 0;
      cap     = 3 * ((mp == 0) ? 1 : mp) + 2;
      if (cap > 60)
         cap = 60;
      while (items_sent - start < n_items) begin
         if (!halfway && items_sent - start >= n_items / 2) begin
            halfway = 1;
            if (mid_pause)
               drain();
            if (mid_stall)
               stall_req++;
         end
         pick = $urandom_range(99);
         len  = $urandom_range(1, cap);
         if (pick < 60) begin
            send_nal_unit(16'(len), int'(len), 1, nal_header());
         end else if (pick < 70) begin
            // ends on its length alone
            send_nal_unit(16'(len), int'(len), 0, nal_header());
         end else if (pick < 82) begin
            len = $urandom_range(2, 65535);
            cnt = $urandom_range(1, 8);
            if (cnt >= len)
               cnt = len - 1;
            send_nal_unit(16'(len), int'(cnt), 1, nal_header());
         end else begin
            cnt = $urandom_range(1, 6);
            repeat (cnt)
               send_nal_byte(8'($urandom),
                             ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(cap)),
                             $urandom_range(3) == 0);
         end
      end
      // close whatever unit is open before the next register write
      send_nal_byte(8'($urandom), 16'($urandom), 1'b1);
   endtask

   initial begin
      int unsigned   mp_set[6]   = '{16, 65535, 0, 23, 40, 1400};
      int unsigned   step_set[6] = '{90000, 131071, 1, 3000, 'h15555, 3000};
      idle_mode_type mode_set[6] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                     IDLE_NONE, IDLE_BOTH};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: parameter sets, zero length, unit ended by length
      send_nal_byte(8'h67, 16'd2, 1'b0);
      send_nal_byte(8'hFF, 16'd2, 1'b1);
      send_nal_byte(8'h68, 16'd0, 1'b1);
      send_nal_byte(8'h00, 16'd2, 1'b0);
      send_nal_byte(8'h80, 16'd2, 1'b0);
      drain();

      write_csr(REG_MAX_PAYLOAD, 32'd2);
      write_csr(REG_TS_STEP, 32'd1);
      // one fragment with both flags
      send_nal_byte(8'h65, 16'd3, 1'b0);
      send_nal_byte(8'hAA, 16'd3, 1'b0);
      send_nal_byte(8'h55, 16'd3, 1'b1);
      // three fragments
      send_nal_byte(8'h41, 16'd6, 1'b0);
      for (int i = 1; i < 6; i++)
         send_nal_byte(8'(i), 16'd6, i == 5);
      // cut short inside a fragment, no end flag
      send_nal_byte(8'hFF, 16'hFFFF, 1'b0);
      send_nal_byte(8'hFF, 16'hFFFF, 1'b0);
      send_nal_byte(8'h00, 16'hFFFF, 1'b0);
      send_nal_byte(8'h11, 16'hFFFF, 1'b1);
      // fragmented unit with only its header byte
      send_nal_byte(8'h67, 16'd9, 1'b1);
      // length shrinks to the current position
      send_nal_byte(8'h61, 16'd5, 1'b0);
      send_nal_byte(8'h33, 16'd5, 1'b0);
      send_nal_byte(8'h44, 16'd2, 1'b0);
      drain();

      for (int p = 0; p < 6; p++) begin
         write_csr(REG_MAX_PAYLOAD, mp_set[p]);
         write_csr(REG_TS_STEP, step_set[p]);
         idle_mode = mode_set[p];
         run_phase(38, mp_set[p], p == 0, p == 2);
         drain();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
